// ===== rtl/core/md5_digest_stream_unit_macros.svh =====
// ----------------------------------------------------------------------------
// md5_digest_stream_unit_macros.svh
// Assertion shorthands for the streaming MD5 unit.
// ----------------------------------------------------------------------------
`ifndef MD5_DIGEST_STREAM_UNIT_MACROS_SVH
`define MD5_DIGEST_STREAM_UNIT_MACROS_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define MD5DSU_AST_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on i_clk, off during reset
`define MD5DSU_AST_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/md5ds_pkg.sv =====
// ----------------------------------------------------------------------------
// md5ds_pkg
// Shared types, constants and helper functions for the streaming MD5 unit.
// ----------------------------------------------------------------------------
`default_nettype none

package md5ds_pkg;

    typedef logic [31:0] t_word;

    typedef struct packed {
        t_word a;
        t_word b;
        t_word c;
        t_word d;
    } t_rvars;

    localparam t_word H0_INIT = 32'h67452301;
    localparam t_word H1_INIT = 32'hefcdab89;
    localparam t_word H2_INIT = 32'h98badcfe;
    localparam t_word H3_INIT = 32'h10325476;

    localparam t_word PAD_WORD = 32'h00000080;

    localparam t_word SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    function automatic logic [4:0] rot_amt(input logic [5:0] rnd);
        logic [4:0] s;
        case ({rnd[5:4], rnd[1:0]})
            4'h0: s = 5'd7;
            4'h1: s = 5'd12;
            4'h2: s = 5'd17;
            4'h3: s = 5'd22;
            4'h4: s = 5'd5;
            4'h5: s = 5'd9;
            4'h6: s = 5'd14;
            4'h7: s = 5'd20;
            4'h8: s = 5'd4;
            4'h9: s = 5'd11;
            4'ha: s = 5'd16;
            4'hb: s = 5'd23;
            4'hc: s = 5'd6;
            4'hd: s = 5'd10;
            4'he: s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    // message word used by a round
    function automatic logic [3:0] msg_index(input logic [5:0] rnd);
        logic [3:0] j;
        logic [3:0] g;
        j = rnd[3:0];
        case (rnd[5:4])
            2'd0: g = j;
            2'd1: g = 4'(j * 4'd5 + 4'd1);
            2'd2: g = 4'(j * 4'd3 + 4'd5);
            default: g = 4'(j * 4'd7);
        endcase
        return g;
    endfunction

    function automatic t_word rotl(input t_word x, input logic [4:0] s);
        logic [63:0] t;
        t = {x, x} << s;
        return t[63:32];
    endfunction

    function automatic t_word swap_bytes(input t_word v);
        return {v[7:0], v[15:8], v[23:16], v[31:24]};
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/md5ds_round.sv =====
// ----------------------------------------------------------------------------
// md5ds_round
// Shared MD5 round datapath: sum of a, f, constant and message word, and the
// rotate-and-add that produces the new b.
// ----------------------------------------------------------------------------
`default_nettype none

module md5ds_round
    import md5ds_pkg::*;
(
    input  wire logic [5:0] i_rnd,
    input  wire t_rvars     i_vars,
    input  wire t_word      i_msg,
    input  wire t_word      i_sum,
    output t_word           o_sum,
    output t_word           o_b_new
);

    t_word f;

    always_comb begin
        case (i_rnd[5:4])
            2'd0: f = (i_vars.b & i_vars.c) | (~i_vars.b & i_vars.d);
            2'd1: f = (i_vars.d & i_vars.b) | (~i_vars.d & i_vars.c);
            2'd2: f = i_vars.b ^ i_vars.c ^ i_vars.d;
            default: f = i_vars.c ^ (i_vars.b | ~i_vars.d);
        endcase
    end

    assign o_sum   = i_vars.a + f + SINE_K[i_rnd] + i_msg;
    assign o_b_new = i_vars.b + rotl(i_sum, rot_amt(i_rnd));

endmodule

`default_nettype wire

// ===== rtl/core/md5_digest_stream_unit.sv =====
// ----------------------------------------------------------------------------
// md5_digest_stream_unit
// Streaming MD5: collects little-endian message words into a 16-word block,
// pads on the last word and returns the byte-reversed digest.
// ----------------------------------------------------------------------------
//  channel | valid        | stall        | payload
//  --------+--------------+--------------+-------------------------------------
//  input   | i_in_valid   | o_in_stall   | i_data_word, i_byte_count,
//          |              |              | i_last_word
//  output  | o_out_valid  | i_out_stall  | o_digest_word0 .. o_digest_word3
//
//  A word that does not complete a block is taken without stalling the input.
//  A full block holds the input while its 64 rounds run on the shared round
//  unit, each forming its sum and then its rotate-and-add, and while the
//  result is folded into the chaining words. The last word adds pad writes
//  up to the block end and one or two such compressions before the digest.
//  Synchronous active-low reset; the output register lets the next message
//  stream in while a digest is stalled, and only the next digest waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "md5_digest_stream_unit_macros.svh"

module md5_digest_stream_unit
    import md5ds_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [31:0] i_data_word,
    input  wire logic [2:0]  i_byte_count,
    input  wire logic        i_last_word,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_digest_word0,
    output logic [31:0]      o_digest_word1,
    output logic [31:0]      o_digest_word2,
    output logic [31:0]      o_digest_word3
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_PAD  = 3'd1;
    localparam logic [2:0] ST_RUN  = 3'd2;
    localparam logic [2:0] ST_FOLD = 3'd3;

    logic [2:0]  r_state, n_state;
    logic [3:0]  r_pos, n_pos;
    logic [63:0] r_len, n_len;
    t_rvars      r_chain, n_chain;
    t_rvars      r_vars, n_vars;
    logic [5:0]  r_rnd, n_rnd;
    logic        r_ph, n_ph;
    logic        r_need80, n_need80;
    logic        r_lo_done, n_lo_done;
    logic        r_in_pad, n_in_pad;
    logic        r_final, n_final;
    logic        r_out_valid, n_out_valid;
    t_word       r_sum, n_sum;
    t_word       r_dig0, n_dig0;
    t_word       r_dig1, n_dig1;
    t_word       r_dig2, n_dig2;
    t_word       r_dig3, n_dig3;
    t_word       r_msg;
    t_word       r_buf [16];

    logic        wr_en;
    t_word       wr_data;
    logic [2:0]  cnt;
    t_word       sum;
    t_word       b_new;
    t_rvars      folded;

    md5ds_round u_round (
        .i_rnd   (r_rnd),
        .i_vars  (r_vars),
        .i_msg   (r_msg),
        .i_sum   (r_sum),
        .o_sum   (sum),
        .o_b_new (b_new)
    );

    assign cnt = (i_byte_count > 3'd4) ? 3'd4 : i_byte_count;

    always_comb begin
        folded.a = r_chain.a + r_vars.a;
        folded.b = r_chain.b + r_vars.b;
        folded.c = r_chain.c + r_vars.c;
        folded.d = r_chain.d + r_vars.d;
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_len       = r_len;
        n_chain     = r_chain;
        n_vars      = r_vars;
        n_rnd       = r_rnd;
        n_ph        = r_ph;
        n_need80    = r_need80;
        n_lo_done   = r_lo_done;
        n_in_pad    = r_in_pad;
        n_final     = r_final;
        n_out_valid = r_out_valid;
        n_sum       = r_sum;
        n_dig0      = r_dig0;
        n_dig1      = r_dig1;
        n_dig2      = r_dig2;
        n_dig3      = r_dig3;
        wr_en       = 1'b0;
        wr_data     = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    wr_en = 1'b1;
                    if (!i_last_word) begin
                        wr_data = i_data_word;
                        n_len   = r_len + 64'd32;
                    end else begin
                        n_len     = r_len + {58'd0, cnt, 3'b000};
                        n_need80  = (cnt == 3'd4);
                        n_lo_done = 1'b0;
                        n_in_pad  = 1'b1;
                        n_state   = ST_PAD;
                        case (cnt)
                            3'd0:    wr_data = PAD_WORD;
                            3'd1:    wr_data = {16'h0000, 8'h80, i_data_word[7:0]};
                            3'd2:    wr_data = {8'h00, 8'h80, i_data_word[15:0]};
                            3'd3:    wr_data = {8'h80, i_data_word[23:0]};
                            default: wr_data = i_data_word;
                        endcase
                    end
                end
            end
            ST_PAD: begin
                wr_en = 1'b1;
                if (r_need80) begin
                    wr_data  = PAD_WORD;
                    n_need80 = 1'b0;
                end else if (r_pos == 4'd14 && !r_lo_done) begin
                    wr_data   = r_len[31:0];
                    n_lo_done = 1'b1;
                end else if (r_pos == 4'd15 && r_lo_done) begin
                    wr_data = r_len[63:32];
                    n_final = 1'b1;
                end else begin
                    wr_data = '0;
                end
            end
            ST_RUN: begin
                if (!r_ph) begin
                    n_sum = sum;
                    n_ph  = 1'b1;
                end else begin
                    n_vars.a = r_vars.d;
                    n_vars.b = b_new;
                    n_vars.c = r_vars.b;
                    n_vars.d = r_vars.c;
                    n_ph     = 1'b0;
                    n_rnd    = r_rnd + 6'd1;
                    if (r_rnd == 6'd63) begin
                        n_state = ST_FOLD;
                    end
                end
            end
            ST_FOLD: begin
                if (!r_final) begin
                    n_chain = folded;
                    n_state = r_in_pad ? ST_PAD : ST_IDLE;
                end else if (!r_out_valid || !i_out_stall) begin
                    n_dig0      = swap_bytes(folded.d);
                    n_dig1      = swap_bytes(folded.c);
                    n_dig2      = swap_bytes(folded.b);
                    n_dig3      = swap_bytes(folded.a);
                    n_out_valid = 1'b1;
                    n_chain     = '{a: H0_INIT, b: H1_INIT, c: H2_INIT, d: H3_INIT};
                    n_len       = '0;
                    n_final     = 1'b0;
                    n_in_pad    = 1'b0;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // block complete: start the rounds
        if (wr_en) begin
            n_pos = r_pos + 4'd1;
            if (r_pos == 4'd15) begin
                n_state = ST_RUN;
                n_rnd   = '0;
                n_ph    = 1'b0;
                n_vars  = r_chain;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pos       <= '0;
            r_len       <= '0;
            r_chain     <= '{a: H0_INIT, b: H1_INIT, c: H2_INIT, d: H3_INIT};
            r_vars      <= '0;
            r_rnd       <= '0;
            r_ph        <= 1'b0;
            r_need80    <= 1'b0;
            r_lo_done   <= 1'b0;
            r_in_pad    <= 1'b0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_len       <= n_len;
            r_chain     <= n_chain;
            r_vars      <= n_vars;
            r_rnd       <= n_rnd;
            r_ph        <= n_ph;
            r_need80    <= n_need80;
            r_lo_done   <= n_lo_done;
            r_in_pad    <= n_in_pad;
            r_final     <= n_final;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum  <= n_sum;
        r_dig0 <= n_dig0;
        r_dig1 <= n_dig1;
        r_dig2 <= n_dig2;
        r_dig3 <= n_dig3;
    end

    // block buffer
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_buf[r_pos] <= wr_data;
        end
        r_msg <= r_buf[msg_index(n_rnd)];
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_digest_word0 = r_dig0;
    assign o_digest_word1 = r_dig1;
    assign o_digest_word2 = r_dig2;
    assign o_digest_word3 = r_dig3;

    `MD5DSU_AST_NXT(a_last_blocks_input, i_in_valid && !o_in_stall && i_last_word, o_in_stall, "last word request did not start padding")
    `MD5DSU_AST_NOW(a_run_pos_zero, r_state == ST_RUN, r_pos == 4'd0, "word position not wrapped during rounds")
    `MD5DSU_AST_NOW(a_digest_from_fold, $rose(r_out_valid), $past(r_state) == ST_FOLD, "digest loaded outside fold")

endmodule

`default_nettype wire
